[hdl/tcee_pkg.sv]
// Package for the tracker channel effect engine: cell and result types,
// effect codes, controller states and commands, period and volume helpers.
// No dependencies.
package tcee_pkg;

  localparam int NUM_CHANNELS    = 4;
  localparam int CHAN_W          = $clog2(NUM_CHANNELS);
  localparam int WAVE_LENGTH     = 64;
  localparam int NOTE_TABLE_SIZE = 36;
  localparam int PERIOD_MAX      = 856;
  localparam int PERIOD_MIN      = 113;
  localparam int VOLUME_MAX      = 63;
  localparam int ARP_DEPTH       = 3 * NUM_CHANNELS;

  // register word index on the configuration port
  localparam logic REG_CHANNEL_ENABLE = 1'b0;

  // effect command nibble
  localparam logic [3:0] FX_ARP        = 4'h0;
  localparam logic [3:0] FX_SLIDE_UP   = 4'h1;
  localparam logic [3:0] FX_SLIDE_DOWN = 4'h2;
  localparam logic [3:0] FX_PORTA      = 4'h3;
  localparam logic [3:0] FX_VIBRATO    = 4'h4;
  localparam logic [3:0] FX_PORTA_VOL  = 4'h5;
  localparam logic [3:0] FX_VIB_VOL    = 4'h6;
  localparam logic [3:0] FX_TREMOLO    = 4'h7;
  localparam logic [3:0] FX_OFFSET     = 4'h9;
  localparam logic [3:0] FX_VOL_SLIDE  = 4'hA;
  localparam logic [3:0] FX_SET_VOL    = 4'hC;
  localparam logic [3:0] FX_EXTENDED   = 4'hE;
  localparam logic [3:0] FX_SPEED      = 4'hF;

  // extended effect sub-command (high nibble of the parameter)
  localparam logic [3:0] EX_FINE_UP    = 4'h1;
  localparam logic [3:0] EX_FINE_DOWN  = 4'h2;
  localparam logic [3:0] EX_VIB_WAVE   = 4'h4;
  localparam logic [3:0] EX_TREM_WAVE  = 4'h7;
  localparam logic [3:0] EX_FVOL_UP    = 4'hA;
  localparam logic [3:0] EX_FVOL_DOWN  = 4'hB;
  localparam logic [3:0] EX_NOTE_CUT   = 4'hC;
  localparam logic [3:0] EX_NOTE_DELAY = 4'hD;

  localparam logic [7:0] SPEED_LIMIT = 8'h20;

  typedef struct packed {
    logic [1:0]  channel;
    logic [4:0]  tick;
    logic [4:0]  speed;
    logic        in_repeat;
    logic [4:0]  sample_number;
    logic [11:0] note_period;
    logic [3:0]  effect;
    logic [7:0]  effect_param;
    logic [6:0]  default_volume;
  } cell_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [9:0]  play_period;
    logic [5:0]  play_volume;
    logic        trigger;
    logic [4:0]  sample_index;
    logic [15:0] start_offset;
    logic        muted;
    logic [4:0]  speed_change;
    logic        song_end;
  } result_t;

  typedef struct packed {
    logic [3:0] wave;
    logic [5:0] pos;
    logic [3:0] speed;
    logic [3:0] depth;
  } lfo_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_DMOD, ST_NOTE, ST_NOTE_FX, ST_ARP,
    ST_LATER, ST_LATER2, ST_COMMIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_TAKE, CMD_FETCH, CMD_DMOD, CMD_NOTE, CMD_NOTE_FX,
    CMD_ARP, CMD_LATER, CMD_LATER2, CMD_COMMIT
  } cmd_t;

  typedef struct packed {
    logic dmod_busy;
    logic out_busy;
  } dp_status_t;

  localparam logic [9:0] NOTE_TABLE [NOTE_TABLE_SIZE] = '{
    10'd856, 10'd808, 10'd762, 10'd720, 10'd678, 10'd640,
    10'd604, 10'd570, 10'd538, 10'd508, 10'd480, 10'd453,
    10'd428, 10'd404, 10'd381, 10'd360, 10'd339, 10'd320,
    10'd302, 10'd285, 10'd269, 10'd254, 10'd240, 10'd226,
    10'd214, 10'd202, 10'd190, 10'd180, 10'd170, 10'd160,
    10'd151, 10'd143, 10'd135, 10'd127, 10'd120, 10'd113
  };

  localparam logic [7:0] QUARTER_SINE [17] = '{
    8'd0, 8'd24, 8'd49, 8'd74, 8'd97, 8'd120, 8'd141, 8'd161, 8'd180,
    8'd197, 8'd212, 8'd224, 8'd235, 8'd244, 8'd250, 8'd253, 8'd254
  };

  // waveform 0 and 3 are sine, 1 ramp down, 2 square
  function automatic logic signed [8:0] wave_value(input logic [3:0] wave,
                                                   input logic [5:0] pos);
    logic [4:0]         i;
    logic [4:0]         qi;
    logic [8:0]         s;
    logic signed [10:0] ramp;
    logic signed [8:0]  v;
    i    = pos[4:0];
    qi   = (i <= 5'd16) ? i : 5'(6'd32 - {1'b0, i});
    s    = {1'b0, QUARTER_SINE[qi]};
    ramp = 11'sd255 - $signed({2'b00, pos, 3'b000});
    case (wave[1:0])
      2'd1: v = ramp[8:0];
      2'd2: v = pos[5] ? -9'sd256 : 9'sd255;
      default: v = pos[5] ? -$signed(s) : $signed(s);
    endcase
    return v;
  endfunction

  function automatic logic [1:0] mod3(input logic [4:0] t);
    logic [1:0] r;
    logic [2:0] x;
    r = 2'd0;
    for (int k = 4; k >= 0; k--) begin
      x = {r, t[k]};
      if (x >= 3'd3) x = x - 3'd3;
      r = x[1:0];
    end
    return r;
  endfunction

  function automatic logic [5:0] sat_volume(input logic signed [9:0] v);
    logic [5:0] r;
    if (v < 10'sd0) r = 6'd0;
    else if (v > 10'(VOLUME_MAX)) r = 6'(VOLUME_MAX);
    else r = v[5:0];
    return r;
  endfunction

  function automatic logic [9:0] clamp_period(input logic signed [13:0] v);
    logic [9:0] r;
    if (v > $signed(14'(PERIOD_MAX))) r = 10'(PERIOD_MAX);
    else if (v < $signed(14'(PERIOD_MIN))) r = 10'(PERIOD_MIN);
    else r = v[9:0];
    return r;
  endfunction

  function automatic logic [11:0] slide_up(input logic [11:0] base,
                                           input logic [7:0] d);
    logic signed [13:0] p;
    p = $signed({2'b00, base}) - $signed({6'd0, d});
    if (d != 8'd0 && p < $signed(14'(PERIOD_MIN))) p = 14'(PERIOD_MIN);
    return p[11:0];
  endfunction

  function automatic logic [11:0] slide_down(input logic [11:0] base,
                                             input logic [7:0] d);
    logic signed [13:0] p;
    p = $signed({2'b00, base}) + $signed({6'd0, d});
    if (d != 8'd0 && p > $signed(14'(PERIOD_MAX))) p = 14'(PERIOD_MAX);
    return p[11:0];
  endfunction

  function automatic logic [11:0] porta_step(input logic [11:0] base,
                                             input logic [11:0] target,
                                             input logic [7:0] rate);
    logic signed [13:0] p;
    logic signed [13:0] t;
    p = $signed({2'b00, base});
    t = $signed({2'b00, target});
    if (target > base) begin
      p = p + $signed({6'd0, rate});
      if (p > t) p = t;
    end else if (target < base) begin
      p = p - $signed({6'd0, rate});
      if (p < t) p = t;
    end
    return p[11:0];
  endfunction

  function automatic logic [5:0] vol_slide(input logic [5:0] vol,
                                           input logic [7:0] prm);
    logic [5:0] r;
    if (prm[7:4] != 4'd0)
      r = sat_volume($signed({4'd0, vol}) + $signed({6'd0, prm[7:4]}));
    else
      r = sat_volume($signed({4'd0, vol}) - $signed({6'd0, prm[3:0]}));
    return r;
  endfunction

  function automatic logic [11:0] arp_step(input logic [6:0] idx);
    logic [11:0] r;
    if (idx < 7'(NOTE_TABLE_SIZE)) r = {2'b00, NOTE_TABLE[idx[5:0]]};
    else if (idx == 7'(NOTE_TABLE_SIZE)) r = 12'd0;
    else r = {2'b00, NOTE_TABLE[6'(idx - 7'(NOTE_TABLE_SIZE + 1))]};
    return r;
  endfunction

endpackage

[hdl/tcee_ctrl.sv]
// Sequencer for the tracker channel effect engine: steps one cell through
// fetch, delay reduction, note tick, later tick and commit.
// Depends on tcee_pkg.
module tcee_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cell_valid,
  output logic                cell_ready,
  input  tcee_pkg::dp_status_t status,
  output tcee_pkg::cmd_t      cmd
);
  import tcee_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (cell_valid) state_next = ST_FETCH;
      ST_FETCH:   state_next = ST_DMOD;
      ST_DMOD:    if (!status.dmod_busy) state_next = ST_NOTE;
      ST_NOTE:    state_next = ST_NOTE_FX;
      ST_NOTE_FX: state_next = ST_ARP;
      ST_ARP:     state_next = ST_LATER;
      ST_LATER:   state_next = ST_LATER2;
      ST_LATER2:  state_next = ST_COMMIT;
      ST_COMMIT:  if (!status.out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_ready = 1'b0;
    cmd        = CMD_NONE;
    case (state)
      ST_IDLE: begin
        cell_ready = 1'b1;
        if (cell_valid) cmd = CMD_TAKE;
      end
      ST_FETCH:   cmd = CMD_FETCH;
      ST_DMOD:    cmd = CMD_DMOD;
      ST_NOTE:    cmd = CMD_NOTE;
      ST_NOTE_FX: cmd = CMD_NOTE_FX;
      ST_ARP:     cmd = CMD_ARP;
      ST_LATER:   cmd = CMD_LATER;
      ST_LATER2:  cmd = CMD_LATER2;
      // hold until the output register is free
      ST_COMMIT:  cmd = status.out_busy ? CMD_NONE : CMD_COMMIT;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule

[hdl/tcee_datapath.sv]
// Datapath of the tracker channel effect engine: per-channel state, working
// registers for the cell in flight, effect arithmetic and the result register.
// Depends on tcee_pkg.
module tcee_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  tcee_pkg::cmd_t       cmd,
  input  tcee_pkg::cell_t      cell_data,
  input  logic [3:0]           channel_enable,
  output tcee_pkg::dp_status_t status,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tcee_pkg::result_t    result
);
  import tcee_pkg::*;

  // per-channel state
  logic [11:0] st_base   [NUM_CHANNELS];
  logic [11:0] st_eff    [NUM_CHANNELS];
  logic [11:0] st_target [NUM_CHANNELS];
  logic [7:0]  st_rate   [NUM_CHANNELS];
  logic [5:0]  st_bvol   [NUM_CHANNELS];
  logic [5:0]  st_evol   [NUM_CHANNELS];
  logic [4:0]  st_smp    [NUM_CHANNELS];
  logic [15:0] st_off    [NUM_CHANNELS];
  logic [15:0] st_offmem [NUM_CHANNELS];
  logic        st_stop   [NUM_CHANNELS];
  logic [4:0]  st_delay  [NUM_CHANNELS];
  logic [3:0]  st_vwave  [NUM_CHANNELS];
  logic [5:0]  st_vpos   [NUM_CHANNELS];
  logic [3:0]  st_vspeed [NUM_CHANNELS];
  logic [3:0]  st_vdepth [NUM_CHANNELS];
  logic [3:0]  st_twave  [NUM_CHANNELS];
  logic [5:0]  st_tpos   [NUM_CHANNELS];
  logic [3:0]  st_tspeed [NUM_CHANNELS];
  logic [3:0]  st_tdepth [NUM_CHANNELS];
  logic [11:0] st_arp    [ARP_DEPTH];

  cell_t cell_r;

  // working registers for the cell in flight
  logic [11:0] w_base, w_base_next;
  logic [11:0] w_eff, w_eff_next;
  logic [11:0] w_target, w_target_next;
  logic [7:0]  w_rate, w_rate_next;
  logic [5:0]  w_bvol, w_bvol_next;
  logic [5:0]  w_evol, w_evol_next;
  logic [4:0]  w_smp, w_smp_next;
  logic [15:0] w_off, w_off_next;
  logic [15:0] w_offmem, w_offmem_next;
  logic        w_stop, w_stop_next;
  logic        w_trig, w_trig_next;
  logic [4:0]  w_delay, w_delay_next;
  logic        w_dmod, w_dmod_next;
  lfo_t        w_vib, w_vib_next;
  lfo_t        w_trem, w_trem_next;
  logic [4:0]  w_spd, w_spd_next;
  logic [4:0]  w_spdout, w_spdout_next;
  logic        w_end, w_end_next;
  logic [5:0]  w_idx, w_idx_next;
  logic        w_found, w_found_next;
  logic signed [13:0] w_prod, w_prod_next;

  logic [CHAN_W-1:0] c;
  logic [3:0]  prm_hi;
  logic [3:0]  prm_lo;
  logic        is_note;
  logic        is_later;
  logic        porta;
  logic        load_new;
  logic [3:0]  arp_base;
  logic [3:0]  arp_rd;
  logic        arp_we;
  logic [11:0] arp1;
  logic [11:0] arp2;
  logic signed [13:0] shifted;
  logic [9:0]  eff_clamped;
  logic        row_end;
  logic [11:0] eff_final;
  logic [4:0]  delay_final;
  result_t     result_next;

  assign c        = cell_r.channel;
  assign prm_hi   = cell_r.effect_param[7:4];
  assign prm_lo   = cell_r.effect_param[3:0];
  assign is_note  = (cell_r.tick == w_delay);
  assign is_later = !is_note && (w_delay == 5'd0);
  assign porta    = (cell_r.effect == FX_PORTA) || (cell_r.effect == FX_PORTA_VOL);
  assign load_new = ((cell_r.note_period != 12'd0) || (cell_r.sample_number != 5'd0))
                    && !cell_r.in_repeat;
  assign arp_base = 4'({c, 1'b0}) + 4'(c);
  assign arp_rd   = arp_base + {2'b00, mod3(cell_r.tick)};

  assign status.dmod_busy = w_dmod && (w_delay >= cell_r.speed);
  assign status.out_busy  = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (cmd == CMD_TAKE) begin
      cell_r <= cell_data;
    end
  end

  always_comb begin
    w_base_next   = w_base;
    w_eff_next    = w_eff;
    w_target_next = w_target;
    w_rate_next   = w_rate;
    w_bvol_next   = w_bvol;
    w_evol_next   = w_evol;
    w_smp_next    = w_smp;
    w_off_next    = w_off;
    w_offmem_next = w_offmem;
    w_stop_next   = w_stop;
    w_trig_next   = w_trig;
    w_delay_next  = w_delay;
    w_dmod_next   = w_dmod;
    w_vib_next    = w_vib;
    w_trem_next   = w_trem;
    w_spd_next    = w_spd;
    w_spdout_next = w_spdout;
    w_end_next    = w_end;
    w_idx_next    = w_idx;
    w_found_next  = w_found;
    w_prod_next   = w_prod;
    shifted       = 14'sd0;
    case (cmd)
      CMD_FETCH: begin
        w_base_next   = st_base[c];
        w_eff_next    = st_eff[c];
        w_target_next = st_target[c];
        w_rate_next   = st_rate[c];
        w_bvol_next   = st_bvol[c];
        w_evol_next   = st_evol[c];
        w_smp_next    = st_smp[c];
        w_off_next    = st_off[c];
        w_offmem_next = st_offmem[c];
        w_stop_next   = st_stop[c];
        w_vib_next    = '{wave: st_vwave[c], pos: st_vpos[c],
                          speed: st_vspeed[c], depth: st_vdepth[c]};
        w_trem_next   = '{wave: st_twave[c], pos: st_tpos[c],
                          speed: st_tspeed[c], depth: st_tdepth[c]};
        w_trig_next   = 1'b0;
        w_spd_next    = cell_r.speed;
        w_spdout_next = 5'd0;
        w_end_next    = 1'b0;
        if (cell_r.tick == 5'd0 && cell_r.effect == FX_EXTENDED &&
            prm_hi == EX_NOTE_DELAY) begin
          w_delay_next = {1'b0, prm_lo};
          w_dmod_next  = (cell_r.speed != 5'd0);
        end else begin
          w_delay_next = st_delay[c];
          w_dmod_next  = 1'b0;
        end
      end
      CMD_DMOD: begin
        // reduce the delay tick modulo the speed, one subtract per cycle
        if (status.dmod_busy) w_delay_next = w_delay - cell_r.speed;
      end
      CMD_NOTE: begin
        if (is_note && load_new) begin
          w_trig_next = 1'b1;
          if (cell_r.sample_number != 5'd0) begin
            w_stop_next = 1'b0;
            if (!porta) w_off_next = 16'd0;
            w_smp_next  = cell_r.sample_number - 5'd1;
            w_bvol_next = sat_volume($signed({3'b000, cell_r.default_volume}));
            w_evol_next = w_bvol_next;
          end
          if (cell_r.note_period != 12'd0) begin
            if (!porta) begin
              if (cell_r.effect == FX_OFFSET) begin
                if (cell_r.effect_param != 8'd0)
                  w_offmem_next = {cell_r.effect_param, 8'd0};
                w_off_next = w_off_next + w_offmem_next;
              end
              w_base_next    = cell_r.note_period;
              w_eff_next     = cell_r.note_period;
              w_stop_next    = 1'b0;
              w_vib_next.pos  = 6'd0;
              w_trem_next.pos = 6'd0;
            end
            w_target_next = cell_r.note_period;
          end
        end
      end
      CMD_NOTE_FX: begin
        if (is_note) begin
          case (cell_r.effect)
            FX_ARP: begin
              if (cell_r.effect_param != 8'd0) begin
                w_base_next  = w_target;
                w_idx_next   = 6'd0;
                w_found_next = 1'b0;
                for (int i = 0; i < NOTE_TABLE_SIZE; i++) begin
                  if ({2'b00, NOTE_TABLE[i]} == w_target) begin
                    w_idx_next   = w_idx_next | 6'(i);
                    w_found_next = 1'b1;
                  end
                end
              end
            end
            FX_PORTA: if (cell_r.effect_param != 8'd0) w_rate_next = cell_r.effect_param;
            FX_VIBRATO: begin
              if (prm_lo != 4'd0) w_vib_next.depth = prm_lo;
              if (prm_hi != 4'd0) w_vib_next.speed = prm_hi;
            end
            FX_TREMOLO: begin
              if (cell_r.effect_param != 8'd0) begin
                w_trem_next.depth = prm_lo;
                w_trem_next.speed = prm_hi;
              end
            end
            FX_SET_VOL: begin
              w_bvol_next = sat_volume($signed({2'b00, cell_r.effect_param}));
              w_evol_next = w_bvol_next;
            end
            FX_EXTENDED: begin
              case (prm_hi)
                EX_FINE_UP: begin
                  w_base_next = slide_up(w_base, {4'd0, prm_lo});
                  w_eff_next  = w_base_next;
                end
                EX_FINE_DOWN: begin
                  w_base_next = slide_down(w_base, {4'd0, prm_lo});
                  w_eff_next  = w_base_next;
                end
                EX_FVOL_UP: begin
                  w_bvol_next = sat_volume($signed({4'd0, w_bvol}) +
                                           $signed({6'd0, prm_lo}));
                  w_evol_next = w_bvol_next;
                end
                EX_FVOL_DOWN: begin
                  w_bvol_next = sat_volume($signed({4'd0, w_bvol}) -
                                           $signed({6'd0, prm_lo}));
                  w_evol_next = w_bvol_next;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          if (w_eff_next == 12'd0) w_stop_next = 1'b1;
        end
      end
      CMD_LATER: begin
        if (is_later) begin
          case (cell_r.effect)
            FX_ARP: if (cell_r.effect_param != 8'd0) w_eff_next = st_arp[arp_rd];
            FX_SLIDE_UP: begin
              w_base_next = slide_up(w_base, cell_r.effect_param);
              w_eff_next  = w_base_next;
            end
            FX_SLIDE_DOWN: begin
              w_base_next = slide_down(w_base, cell_r.effect_param);
              w_eff_next  = w_base_next;
            end
            FX_PORTA, FX_PORTA_VOL: begin
              if (cell_r.effect == FX_PORTA_VOL) begin
                w_bvol_next = vol_slide(w_bvol, cell_r.effect_param);
                w_evol_next = w_bvol_next;
              end
              w_base_next = porta_step(w_base, w_target, w_rate);
              w_eff_next  = w_base_next;
            end
            FX_VIBRATO, FX_VIB_VOL: begin
              if (cell_r.effect == FX_VIB_VOL) begin
                w_bvol_next = vol_slide(w_bvol, cell_r.effect_param);
                w_evol_next = w_bvol_next;
              end
              w_prod_next = $signed({1'b0, w_vib.depth}) *
                            wave_value(w_vib.wave, w_vib.pos);
            end
            FX_TREMOLO: begin
              w_prod_next = $signed({1'b0, w_trem.depth}) *
                            wave_value(w_trem.wave, w_trem.pos);
            end
            FX_VOL_SLIDE: begin
              w_bvol_next = vol_slide(w_bvol, cell_r.effect_param);
              w_evol_next = w_bvol_next;
            end
            FX_EXTENDED: begin
              if (prm_hi == EX_VIB_WAVE) begin
                w_vib_next.wave = prm_lo;
              end else if (prm_hi == EX_TREM_WAVE) begin
                w_trem_next.wave = prm_lo;
              end else if (prm_hi == EX_NOTE_CUT && cell_r.tick == {1'b0, prm_lo}) begin
                w_bvol_next = 6'd0;
                w_evol_next = 6'd0;
              end
            end
            FX_SPEED: begin
              if (cell_r.effect_param == 8'd0) begin
                w_end_next = 1'b1;
              end else if (cell_r.effect_param < SPEED_LIMIT) begin
                w_spd_next    = cell_r.effect_param[4:0];
                w_spdout_next = cell_r.effect_param[4:0];
              end
            end
            default: ;
          endcase
        end
      end
      CMD_LATER2: begin
        if (is_later) begin
          case (cell_r.effect)
            FX_VIBRATO, FX_VIB_VOL: begin
              shifted        = w_prod >>> 7;
              w_eff_next     = {2'b00, clamp_period($signed({2'b00, w_base}) + shifted)};
              w_vib_next.pos = w_vib.pos + {2'b00, w_vib.speed};
            end
            FX_TREMOLO: begin
              shifted         = w_prod >>> 6;
              w_evol_next     = sat_volume($signed({4'd0, w_bvol}) +
                                           $signed(shifted[9:0]));
              w_trem_next.pos = w_trem.pos + {2'b00, w_trem.speed};
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    w_base   <= w_base_next;
    w_eff    <= w_eff_next;
    w_target <= w_target_next;
    w_rate   <= w_rate_next;
    w_bvol   <= w_bvol_next;
    w_evol   <= w_evol_next;
    w_smp    <= w_smp_next;
    w_off    <= w_off_next;
    w_offmem <= w_offmem_next;
    w_stop   <= w_stop_next;
    w_trig   <= w_trig_next;
    w_delay  <= w_delay_next;
    w_dmod   <= w_dmod_next;
    w_vib    <= w_vib_next;
    w_trem   <= w_trem_next;
    w_spd    <= w_spd_next;
    w_spdout <= w_spdout_next;
    w_end    <= w_end_next;
    w_idx    <= w_idx_next;
    w_found  <= w_found_next;
    w_prod   <= w_prod_next;
  end

  // arpeggio periods, written on the note tick of an arpeggio cell with a nonzero parameter
  assign arp_we = (cmd == CMD_ARP) && is_note && (cell_r.effect == FX_ARP) &&
                  (cell_r.effect_param != 8'd0);
  assign arp1   = w_found ? arp_step({1'b0, w_idx} + {3'b000, prm_hi}) : w_base;
  assign arp2   = w_found ? arp_step({1'b0, w_idx} + {3'b000, prm_lo}) : w_base;

  always_ff @(posedge clk) begin
    if (arp_we) begin
      st_arp[arp_base]        <= w_base;
      st_arp[arp_base + 4'd1] <= arp1;
      st_arp[arp_base + 4'd2] <= arp2;
    end
  end

  // commit: clamp, row end reload, write back
  assign eff_clamped = clamp_period($signed({2'b00, w_eff}));
  assign row_end     = (w_spd != 5'd0) && (cell_r.tick == w_spd - 5'd1);
  assign eff_final   = row_end ? w_base : {2'b00, eff_clamped};
  assign delay_final = row_end ? 5'd0 : w_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        st_base[i]   <= '0;
        st_eff[i]    <= '0;
        st_target[i] <= '0;
        st_rate[i]   <= '0;
        st_bvol[i]   <= '0;
        st_evol[i]   <= '0;
        st_smp[i]    <= '0;
        st_off[i]    <= '0;
        st_offmem[i] <= '0;
        st_stop[i]   <= 1'b1;
        st_delay[i]  <= '0;
        st_vwave[i]  <= '0;
        st_vpos[i]   <= '0;
        st_twave[i]  <= '0;
        st_tpos[i]   <= '0;
      end
    end else if (cmd == CMD_COMMIT) begin
      st_base[c]   <= w_base;
      st_eff[c]    <= eff_final;
      st_target[c] <= w_target;
      st_rate[c]   <= w_rate;
      st_bvol[c]   <= w_bvol;
      st_evol[c]   <= w_evol;
      st_smp[c]    <= w_smp;
      st_off[c]    <= w_off;
      st_offmem[c] <= w_offmem;
      st_stop[c]   <= w_stop;
      st_delay[c]  <= delay_final;
      st_vwave[c]  <= w_vib.wave;
      st_vpos[c]   <= w_vib.pos;
      st_twave[c]  <= w_trem.wave;
      st_tpos[c]   <= w_trem.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_COMMIT) begin
      st_vspeed[c] <= w_vib.speed;
      st_vdepth[c] <= w_vib.depth;
      st_tspeed[c] <= w_trem.speed;
      st_tdepth[c] <= w_trem.depth;
    end
  end

  always_comb begin
    result_next.out_channel  = cell_r.channel;
    result_next.play_period  = clamp_period($signed({2'b00, eff_final}));
    result_next.play_volume  = w_stop ? 6'd0 : w_evol;
    result_next.trigger      = (cell_r.tick == 5'd0) && w_trig && !w_stop &&
                               channel_enable[c];
    result_next.sample_index = w_smp;
    result_next.start_offset = w_off;
    result_next.muted        = w_stop;
    result_next.speed_change = w_spdout;
    result_next.song_end     = w_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd == CMD_COMMIT) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_COMMIT) begin
      result <= result_next;
    end
  end

endmodule

[hdl/tracker_channel_effect_engine_unit.sv]
// Tracker channel effect engine: one pattern cell in, one result out.
// A cell passes the sequencer states fetch, delay reduction (repeated subtract
// of the note delay modulo speed), note tick, later tick and commit.
// The next cell is taken once the sequencer is back in idle, while the result
// register may still be held.
// Reset (synchronous, rst high): all channels stopped, periods, volumes and
// offsets zero, channel_enable all ones. Depends on tcee_pkg.
module tracker_channel_effect_engine_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cell_valid,
  output logic             cell_ready,
  input  tcee_pkg::cell_t  cell_data,
  output logic             result_valid,
  input  logic             result_ready,
  output tcee_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcee_pkg::*;

  logic       [3:0] channel_enable;
  cmd_t       cmd;
  dp_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= 4'hF;
    end else if (psel && penable && pwrite && paddr[2] == REG_CHANNEL_ENABLE) begin
      channel_enable <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_CHANNEL_ENABLE) ? {28'd0, channel_enable} : 32'd0;

  tcee_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .status     (status),
    .cmd        (cmd)
  );

  tcee_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cell_data      (cell_data),
    .channel_enable (channel_enable),
    .status         (status),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

endmodule

[tb/sv/tracker_channel_effect_engine_unit_chk.sv]
// Checker for the tracker channel effect engine: watches the cell, result and
// configuration ports, predicts each result per channel and compares it.
// Depends on tcee_pkg.
module tracker_channel_effect_engine_unit_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              cell_valid,
  input  logic              cell_ready,
  input  tcee_pkg::cell_t   cell_data,
  input  logic              result_valid,
  input  logic              result_ready,
  input  tcee_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fails,
  output int                pending
);
  import tcee_pkg::*;

  int        chan_en;
  int        base_p [NUM_CHANNELS];
  int        eff_p [NUM_CHANNELS];
  int        tgt_p [NUM_CHANNELS];
  int        porta_rate [NUM_CHANNELS];
  int        base_vol [NUM_CHANNELS];
  int        eff_vol [NUM_CHANNELS];
  int        smp_cur [NUM_CHANNELS];
  int        offs [NUM_CHANNELS];
  int        off_mem [NUM_CHANNELS];
  int        halted [NUM_CHANNELS];
  int        dly [NUM_CHANNELS];
  int        arp_p [NUM_CHANNELS][3];
  int        vib_wave [NUM_CHANNELS], vib_pos [NUM_CHANNELS];
  int        vib_spd [NUM_CHANNELS], vib_dep [NUM_CHANNELS];
  int        trem_wave [NUM_CHANNELS], trem_pos [NUM_CHANNELS];
  int        trem_spd [NUM_CHANNELS], trem_dep [NUM_CHANNELS];
  result_t   expected_results [$];

  assign pending = expected_results.size();

  function automatic int lfo_level(int w, int pos);
    int p, i, s;
    p = pos % WAVE_LENGTH;
    i = p & 31;
    case (w & 3)
      1: return 255 - 8 * p;
      2: return (p < 32) ? 255 : -256;
      default: begin
        s = (i <= 16) ? QUARTER_SINE[i] : QUARTER_SINE[32 - i];
        return (p < 32) ? s : -s;
      end
    endcase
  endfunction

  function automatic int vol_sat(int v);
    return (v < 0) ? 0 : (v > VOLUME_MAX) ? VOLUME_MAX : v;
  endfunction

  function automatic int period_clamp(int v);
    return (v > PERIOD_MAX) ? PERIOD_MAX : (v < PERIOD_MIN) ? PERIOD_MIN : v;
  endfunction

  function automatic int arp_note(int idx);
    if (idx < NOTE_TABLE_SIZE) return NOTE_TABLE[idx];
    if (idx == NOTE_TABLE_SIZE) return 0;
    return NOTE_TABLE[(idx - 1) % NOTE_TABLE_SIZE];
  endfunction

  function automatic void put_vol(int c, int v);
    base_vol[c] = vol_sat(v);
    eff_vol[c]  = base_vol[c];
  endfunction

  function automatic void slide_vol(int c, int prm);
    if (prm >> 4) put_vol(c, base_vol[c] + (prm >> 4));
    else put_vol(c, base_vol[c] - (prm & 15));
  endfunction

  function automatic void shift_period(int c, int delta);
    int p;
    p = base_p[c] + delta;
    if (delta < 0 && p < PERIOD_MIN) p = PERIOD_MIN;
    if (delta > 0 && p > PERIOD_MAX) p = PERIOD_MAX;
    base_p[c] = p & 16'hffff;
    eff_p[c]  = base_p[c];
  endfunction

  function automatic result_t predict_result(cell_t x);
    int      c, t, spd, smp, note, fx, prm, dv, p, idx, new_spd;
    bit      rep, trig, fin, porta;
    result_t r;
    c = x.channel % NUM_CHANNELS;
    t = x.tick; spd = x.speed; rep = x.in_repeat; smp = x.sample_number;
    note = x.note_period; fx = x.effect; prm = x.effect_param; dv = x.default_volume;
    trig = 0; fin = 0; new_spd = 0;

    if (t == 0 && fx == FX_EXTENDED && (prm >> 4) == EX_NOTE_DELAY)
      dly[c] = (spd != 0) ? (prm & 15) % spd : (prm & 15);

    if (t == dly[c]) begin
      porta = (fx == FX_PORTA || fx == FX_PORTA_VOL);
      if ((note != 0 || smp != 0) && !rep) begin
        trig = 1;
        if (smp != 0) begin
          halted[c] = 0;
          if (!porta) offs[c] = 0;
          smp_cur[c] = (smp - 1) & 31;
          put_vol(c, dv);
        end
        if (note != 0) begin
          if (!porta) begin
            if (fx == FX_OFFSET) begin
              if (prm != 0) off_mem[c] = prm << 8;
              offs[c] = (offs[c] + off_mem[c]) & 16'hffff;
            end
            base_p[c] = note;
            eff_p[c] = note;
            halted[c] = 0;
            vib_pos[c] = 0;
            trem_pos[c] = 0;
          end
          tgt_p[c] = note;
        end
      end
      case (fx)
        FX_ARP: if (prm != 0) begin
          base_p[c] = tgt_p[c];
          idx = -1;
          for (int k = NOTE_TABLE_SIZE - 1; k >= 0; k--)
            if (NOTE_TABLE[k] == base_p[c]) idx = k;
          arp_p[c][0] = base_p[c];
          arp_p[c][1] = (idx < 0) ? base_p[c] : arp_note(idx + (prm >> 4));
          arp_p[c][2] = (idx < 0) ? base_p[c] : arp_note(idx + (prm & 15));
        end
        FX_PORTA: if (prm != 0) porta_rate[c] = prm;
        FX_VIBRATO: begin
          if (prm & 15) vib_dep[c] = prm & 15;
          if (prm >> 4) vib_spd[c] = prm >> 4;
        end
        FX_TREMOLO: if (prm != 0) begin
          trem_dep[c] = prm & 15;
          trem_spd[c] = prm >> 4;
        end
        FX_SET_VOL: put_vol(c, prm);
        FX_EXTENDED: case (prm >> 4)
          EX_FINE_UP:   shift_period(c, -(prm & 15));
          EX_FINE_DOWN: shift_period(c, prm & 15);
          EX_FVOL_UP:   put_vol(c, base_vol[c] + (prm & 15));
          EX_FVOL_DOWN: put_vol(c, base_vol[c] - (prm & 15));
          default: ;
        endcase
        default: ;
      endcase
      if (eff_p[c] == 0) halted[c] = 1;
    end else if (dly[c] == 0) begin
      case (fx)
        FX_ARP: if (prm != 0) eff_p[c] = arp_p[c][t % 3];
        FX_SLIDE_UP: shift_period(c, -prm);
        FX_SLIDE_DOWN: shift_period(c, prm);
        FX_PORTA, FX_PORTA_VOL: begin
          if (fx == FX_PORTA_VOL) slide_vol(c, prm);
          p = base_p[c];
          if (tgt_p[c] > base_p[c]) begin
            p += porta_rate[c];
            if (p > tgt_p[c]) p = tgt_p[c];
          end else if (tgt_p[c] < base_p[c]) begin
            p -= porta_rate[c];
            if (p < tgt_p[c]) p = tgt_p[c];
          end
          base_p[c] = p & 16'hffff;
          eff_p[c] = base_p[c];
        end
        FX_VIBRATO, FX_VIB_VOL: begin
          if (fx == FX_VIB_VOL) slide_vol(c, prm);
          eff_p[c] = period_clamp(base_p[c] +
                     ((vib_dep[c] * lfo_level(vib_wave[c], vib_pos[c])) >>> 7));
          vib_pos[c] = (vib_pos[c] + vib_spd[c]) % WAVE_LENGTH;
        end
        FX_TREMOLO: begin
          eff_vol[c] = vol_sat(base_vol[c] +
                       ((trem_dep[c] * lfo_level(trem_wave[c], trem_pos[c])) >>> 6));
          trem_pos[c] = (trem_pos[c] + trem_spd[c]) % WAVE_LENGTH;
        end
        FX_VOL_SLIDE: slide_vol(c, prm);
        FX_EXTENDED: begin
          if ((prm >> 4) == EX_VIB_WAVE) vib_wave[c] = prm & 15;
          else if ((prm >> 4) == EX_TREM_WAVE) trem_wave[c] = prm & 15;
          else if ((prm >> 4) == EX_NOTE_CUT && t == (prm & 15)) put_vol(c, 0);
        end
        FX_SPEED: begin
          if (prm == 0) fin = 1;
          else if (prm < SPEED_LIMIT) begin
            spd = prm;
            new_spd = prm;
          end
        end
        default: ;
      endcase
    end

    eff_p[c] = period_clamp(eff_p[c]);
    if (spd != 0 && t == spd - 1) begin
      eff_p[c] = base_p[c];
      dly[c] = 0;
    end

    r.out_channel  = x.channel;
    r.play_period  = 10'(period_clamp(eff_p[c]));
    r.play_volume  = halted[c] ? 6'd0 : 6'(eff_vol[c]);
    r.trigger      = (t == 0 && trig && !halted[c] && chan_en[c & 3]);
    r.sample_index = 5'(smp_cur[c]);
    r.start_offset = 16'(offs[c]);
    r.muted        = halted[c][0];
    r.speed_change = 5'(new_spd);
    r.song_end     = fin;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t %s: got %0d, want %0d", $time, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      chan_en = 15;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        base_p[c] = 0; eff_p[c] = 0; tgt_p[c] = 0; porta_rate[c] = 0;
        base_vol[c] = 0; eff_vol[c] = 0; smp_cur[c] = 0; offs[c] = 0;
        off_mem[c] = 0; halted[c] = 1; dly[c] = 0;
        arp_p[c][0] = 0; arp_p[c][1] = 0; arp_p[c][2] = 0;
        vib_wave[c] = 0; vib_pos[c] = 0; vib_spd[c] = 0; vib_dep[c] = 0;
        trem_wave[c] = 0; trem_pos[c] = 0; trem_spd[c] = 0; trem_dep[c] = 0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(REG_CHANNEL_ENABLE * 4))
        chan_en = pwdata[3:0];
      if (cell_valid && cell_ready)
        expected_results.push_back(predict_result(cell_data));
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report("result transfer with nothing expected", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (result.out_channel != want.out_channel)
            report("out_channel", result.out_channel, want.out_channel);
          if (result.play_period != want.play_period)
            report("play_period", result.play_period, want.play_period);
          if (result.play_volume != want.play_volume)
            report("play_volume", result.play_volume, want.play_volume);
          if (result.trigger != want.trigger)
            report("trigger", result.trigger, want.trigger);
          if (result.sample_index != want.sample_index)
            report("sample_index", result.sample_index, want.sample_index);
          if (result.start_offset != want.start_offset)
            report("start_offset", result.start_offset, want.start_offset);
          if (result.muted != want.muted)
            report("muted", result.muted, want.muted);
          if (result.speed_change != want.speed_change)
            report("speed_change", result.speed_change, want.speed_change);
          if (result.song_end != want.song_end)
            report("song_end", result.song_end, want.song_end);
        end
      end
    end
  end

endmodule

[tb/sv/tracker_channel_effect_engine_unit_tb.sv]
// Testbench top for the tracker channel effect engine: drives pattern cells
// and channel_enable writes, gives the verdict. Depends on tcee_pkg, the
// engine and tracker_channel_effect_engine_unit_chk.
module tracker_channel_effect_engine_unit_tb;
  import tcee_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        cell_valid;
  logic        cell_ready;
  cell_t       cell_data;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  bit          jitter;
  int          sent;
  int          quiet_cycles;

  tracker_channel_effect_engine_unit DUT (.*);

  tracker_channel_effect_engine_unit_chk u_chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  always @(negedge clk)
    result_ready = jitter ? ($urandom_range(99) >= 19) : 1'b1;

  always @(posedge clk) begin
    if (rst || (cell_valid && cell_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tracker_channel_effect_engine_unit: mismatch");
      $finish;
    end
  end

  function automatic cell_t mk_cell(int ch, int tk, int sp, int rep, int smp, int note,
                                    logic [3:0] fx, int prm, int dv);
    cell_t x;
    x.channel = 2'(ch); x.tick = 5'(tk); x.speed = 5'(sp); x.in_repeat = 1'(rep);
    x.sample_number = 5'(smp); x.note_period = 12'(note); x.effect = fx;
    x.effect_param = 8'(prm); x.default_volume = 7'(dv);
    return x;
  endfunction

  // hold valid and payload until the transfer; ready is stable at the falling edge
  task automatic send_cell(cell_t x);
    bit rdy;
    while (jitter && $urandom_range(99) < 19) begin
      cell_valid = 1'b0;
      @(negedge clk);
    end
    cell_data = x;
    cell_valid = 1'b1;
    forever begin
      rdy = cell_ready;
      @(posedge clk);
      if (rdy) break;
      @(negedge clk);
    end
    @(negedge clk);
    cell_valid = 1'b0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_enable(int v);
    drain();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 3'(REG_CHANNEL_ENABLE * 4); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // one row of cells: the same effect on every tick, notes mostly on tick zero
  task automatic play_row();
    int          sp, nt, smp, prm, dv, rep;
    logic [3:0]  fx [4];
    int          fp [4];
    logic [63:0] raw;
    cell_t       x;
    sp = ($urandom_range(19) == 0) ? $urandom_range(31, 1) : $urandom_range(8, 1);
    for (int c = 0; c < 4; c++) begin
      fx[c] = 4'($urandom_range(15));
      fp[c] = $urandom_range(255);
    end
    for (int t = 0; t < sp; t++)
      for (int c = 0; c < 4; c++) begin
        if ($urandom_range(19) == 0) begin
          raw = {$urandom(), $urandom()};
          x = raw[$bits(cell_t)-1:0];
          x.speed = 5'($urandom_range(31, 1));
          x.default_volume = 7'($urandom_range(64));
          send_cell(x);
        end
        nt = 0; smp = 0;
        if (t == 0 || $urandom_range(9) == 0) begin
          case ($urandom_range(9))
            0: nt = $urandom_range(4095);
            1, 2, 3: nt = 0;
            default: nt = NOTE_TABLE[$urandom_range(NOTE_TABLE_SIZE - 1)];
          endcase
          smp = $urandom_range(1) ? $urandom_range(31) : 0;
        end
        dv = $urandom_range(64);
        rep = ($urandom_range(9) == 0);
        prm = ($urandom_range(9) == 0) ? $urandom_range(255) : fp[c];
        send_cell(mk_cell(c, t, sp, rep, smp, nt, fx[c], prm, dv));
      end
  endtask

  initial begin
    rst = 1'b1; cell_valid = 1'b0; cell_data = '0; result_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    jitter = 1'b1; sent = 0; quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // load arpeggio, vibrato and tremolo memory on every channel first
    for (int c = 0; c < 4; c++) begin
      send_cell(mk_cell(c, 0, 6, 0, 1, 428, FX_ARP, 8'h37, 40));
      send_cell(mk_cell(c, 0, 6, 0, 0, 0, FX_VIBRATO, 8'hff, 0));
      send_cell(mk_cell(c, 0, 6, 0, 0, 0, FX_TREMOLO, 8'h8f, 0));
    end
    // field extremes and special cases
    send_cell(mk_cell(0, 0, 31, 0, 31, 4095, FX_OFFSET, 8'hff, 64));
    send_cell(mk_cell(1, 0, 6, 0, 1, 113, FX_ARP, 8'hff, 64));
    send_cell(mk_cell(1, 1, 6, 0, 0, 0, FX_ARP, 8'hff, 0));
    send_cell(mk_cell(2, 1, 6, 0, 0, 0, FX_SPEED, 8'h00, 0));
    send_cell(mk_cell(2, 2, 6, 0, 0, 0, FX_SPEED, 8'h1f, 0));
    send_cell(mk_cell(2, 3, 6, 0, 0, 0, FX_SPEED, 8'h20, 0));
    send_cell(mk_cell(3, 0, 4, 0, 2, 856, FX_EXTENDED, 8'hdf, 0));
    send_cell(mk_cell(3, 3, 4, 0, 2, 856, FX_EXTENDED, 8'hdf, 0));
    send_cell(mk_cell(0, 2, 6, 0, 0, 0, FX_EXTENDED, 8'hc2, 0));
    send_cell(mk_cell(1, 2, 6, 0, 0, 0, FX_EXTENDED, 8'h43, 0));
    send_cell(mk_cell(1, 3, 6, 1, 31, 4095, FX_VIBRATO, 8'h00, 0));
    send_cell(mk_cell(0, 4, 6, 0, 0, 0, FX_SLIDE_DOWN, 8'hff, 0));

    write_enable(0);
    for (int r = 0; r < 6; r++) play_row();
    write_enable(15);
    while (sent < 1600) begin
      jitter = !(sent >= 500 && sent < 800);
      if (sent >= 900 && sent < 1300 && (sent & 1)) begin
        write_enable($urandom_range(15));
        sent++;
      end
      if (sent >= 1000 && sent < 1040) drain();
      play_row();
    end
    write_enable(5);
    play_row();
    write_enable(10);
    play_row();

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fails == 0)
      $display("tracker_channel_effect_engine_unit: match");
    else
      $display("tracker_channel_effect_engine_unit: mismatch");
    $finish;
  end

endmodule

[sim.f]
hdl/tcee_pkg.sv
hdl/tcee_ctrl.sv
hdl/tcee_datapath.sv
hdl/tracker_channel_effect_engine_unit.sv
tb/sv/tracker_channel_effect_engine_unit_chk.sv
tb/sv/tracker_channel_effect_engine_unit_tb.sv
